>>> sv/cpa_pkg.sv
// Shared types and constants of the chunk pool allocator.
`timescale 1ns / 1ps
package cpa_pkg;
   localparam int MaxBlocks      = 16;
   localparam int FreeEntries    = 64;
   localparam int MaxBlockChunks = 4096;

   localparam int BlkW = 4;
   localparam int ChkW = 12;
   localparam int CntW = 13;
   localparam int NumW = 25;
   localparam int CsW  = 17;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NO_BLOCKS  = 3'd1;
   localparam logic [2:0] ST_TOO_LARGE  = 3'd2;
   localparam logic [2:0] ST_BAD_FREE   = 3'd3;
   localparam logic [2:0] ST_TABLE_FULL = 3'd4;

   localparam logic [1:0] REG_PAYLOAD = 2'd0;
   localparam logic [1:0] REG_HEADER  = 2'd1;
   localparam logic [1:0] REG_BLOCK   = 2'd2;

   localparam logic REQ_ALLOC = 1'b0;

   typedef struct packed {
      logic [BlkW-1:0] blk;
      logic [ChkW-1:0] chk;
      logic [CntW-1:0] cnt;
   } entry_type;
endpackage

>>> sv/cpa_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module cpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> sv/chunk_pool_allocator_unit.sv
// Top level of the chunk pool allocator.
`timescale 1ns / 1ps
// One request at a time: an allocate runs a bit-serial divider that sizes the
// run, then walks the sorted free table in RAM entry by entry (read, then
// evaluate); removing a granted entry or inserting a freed run shifts the
// table with the same read and evaluate steps per entry. Result beats sit in
// an output register, so the next request can be taken while a result waits;
// that request then holds in its final state until the waiting result is taken.
module chunk_pool_allocator_unit
   import cpa_pkg::*;
#(
   parameter int MAX_BLOCKS   = MaxBlocks,
   parameter int FREE_ENTRIES = FreeEntries
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [23:0] req_alloc_bytes,
   input  logic [3:0]  req_free_block,
   input  logic [11:0] req_free_chunk,
   input  logic [12:0] req_free_chunks,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_block_index,
   output logic [11:0] rsp_chunk_index,
   output logic [12:0] rsp_chunks_granted
);
   localparam int IW  = $clog2(FREE_ENTRIES);
   localparam int CW  = $clog2(FREE_ENTRIES + 1);
   localparam int BUW = $clog2(MAX_BLOCKS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_DIV, S_CHECK, S_SRD, S_SEV, S_MRD, S_MEV,
      S_BUMP, S_FREE, S_IRD, S_IEV, S_IFIN, S_OPEN, S_FIN
   } state_type;

   state_type        state_ff, state_in;
   logic [15:0]      pay_ff, pay_in;
   logic [7:0]       hdr_ff, hdr_in;
   logic [12:0]      bcr_ff, bcr_in;
   logic [3:0]       fblk_ff, fblk_in;
   logic [11:0]      fchk_ff, fchk_in;
   logic [12:0]      fcnt_ff, fcnt_in;
   logic [NumW-1:0]  num_ff, num_in;
   logic [CsW:0]     rem_ff, rem_in;
   logic [CsW-1:0]   cs_ff, cs_in;
   logic [4:0]       dcnt_ff, dcnt_in;
   logic [12:0]      need_ff, need_in;
   logic [IW-1:0]    i_ff, i_in;
   logic [CW-1:0]    fc_ff, fc_in;
   logic [BUW-1:0]   tb_ff, tb_in;
   logic [BUW-1:0]   biu_ff, biu_in;
   logic [12:0]      tc_ff, tc_in;
   entry_type        ins_ff, ins_in;
   logic             open_ff, open_in;
   logic [2:0]       st_ff, st_in;
   entry_type        res_ff, res_in;
   logic             rv_ff, rv_in;
   logic [2:0]       ost_ff, ost_in;
   entry_type        ores_ff, ores_in;

   logic             ram_we;
   logic [IW-1:0]    ram_waddr;
   entry_type        ram_wdata, ram_rdata;

   logic [12:0]      bc;
   logic [CsW-1:0]   cs_now;
   logic [CsW:0]     rem_sh;
   logic [31:0]      tb32, biu32;
   logic             fits, tail;

   cpa_ram #(.WIDTH($bits(entry_type)), .DEPTH(FREE_ENTRIES)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (i_ff),
      .rd_data (ram_rdata)
   );

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rv_ff;
   assign rsp_status         = ost_ff;
   assign rsp_block_index    = ores_ff.blk;
   assign rsp_chunk_index    = ores_ff.chk;
   assign rsp_chunks_granted = ores_ff.cnt;

   always_comb begin
      if (bcr_ff < 13'd2) begin
         bc = 13'd2;
      end else if (bcr_ff > 13'(MaxBlockChunks)) begin
         bc = 13'(MaxBlockChunks);
      end else begin
         bc = bcr_ff;
      end
      cs_now = CsW'(((pay_ff == 16'd0) ? 16'd1 : pay_ff)) + CsW'(hdr_ff);
      rem_sh = {rem_ff[CsW-1:0], num_ff[NumW-1]};
      tb32   = 32'(tb_ff);
      biu32  = 32'(biu_ff);
      fits   = (biu_ff != '0) && ((14'(tc_ff) + 14'(need_ff)) < 14'(bc));
      tail   = (biu_ff != '0) && (tc_ff < bc);
   end

   always_comb begin
      state_in = state_ff;
      pay_in = pay_ff;   hdr_in = hdr_ff;   bcr_in = bcr_ff;
      fblk_in = fblk_ff; fchk_in = fchk_ff; fcnt_in = fcnt_ff;
      num_in = num_ff;   rem_in = rem_ff;   cs_in = cs_ff;     dcnt_in = dcnt_ff;
      need_in = need_ff; i_in = i_ff;       fc_in = fc_ff;
      tb_in = tb_ff;     biu_in = biu_ff;   tc_in = tc_ff;
      ins_in = ins_ff;   open_in = open_ff; st_in = st_ff;     res_in = res_ff;
      rv_in = rv_ff;     ost_in = ost_ff;   ores_in = ores_ff;
      ram_we = 1'b0;
      ram_waddr = i_ff;
      ram_wdata = ram_rdata;

      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end

      if (csr_write) begin
         case (csr_index)
            REG_PAYLOAD: pay_in = csr_data;
            REG_HEADER:  hdr_in = csr_data[7:0];
            REG_BLOCK:   bcr_in = csr_data[12:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               fblk_in = req_free_block;
               fchk_in = req_free_chunk;
               fcnt_in = req_free_chunks;
               st_in   = ST_OK;
               res_in  = '0;
               cs_in   = cs_now;
               num_in  = NumW'(req_alloc_bytes) + NumW'(hdr_ff) + NumW'(cs_now)
                         - NumW'(1);
               rem_in  = '0;
               dcnt_in = 5'(NumW - 1);
               state_in = (req_type == REQ_ALLOC) ? S_DIV : S_FREE;
            end
         end
         S_DIV: begin
            // one quotient bit a cycle, shifted into the numerator register
            if (rem_sh >= (CsW + 1)'(cs_ff)) begin
               rem_in = rem_sh - (CsW + 1)'(cs_ff);
               num_in = {num_ff[NumW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               num_in = {num_ff[NumW-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff - 5'd1;
            if (dcnt_ff == '0) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (num_ff >= NumW'(bc)) begin
               st_in = ST_TOO_LARGE;
               state_in = S_FIN;
            end else begin
               need_in = (num_ff == '0) ? 13'd1 : num_ff[12:0];
               i_in = '0;
               state_in = (fc_ff == '0) ? S_BUMP : S_SRD;
            end
         end
         S_SRD: state_in = S_SEV;
         S_SEV: begin
            if (ram_rdata.cnt >= need_ff) begin
               res_in = ram_rdata;
               if ((CW'(i_ff) + CW'(1)) < fc_ff) begin
                  i_in = IW'(i_ff + 1'b1);
                  state_in = S_MRD;
               end else begin
                  fc_in = fc_ff - CW'(1);
                  state_in = S_FIN;
               end
            end else if ((CW'(i_ff) + CW'(1)) == fc_ff) begin
               state_in = S_BUMP;
            end else begin
               i_in = IW'(i_ff + 1'b1);
               state_in = S_SRD;
            end
         end
         S_MRD: state_in = S_MEV;
         S_MEV: begin
            // close the gap: move the entry down one place
            ram_we = 1'b1;
            ram_waddr = IW'(i_ff - 1'b1);
            if ((CW'(i_ff) + CW'(1)) < fc_ff) begin
               i_in = IW'(i_ff + 1'b1);
               state_in = S_MRD;
            end else begin
               fc_in = fc_ff - CW'(1);
               state_in = S_FIN;
            end
         end
         S_BUMP: begin
            if (fits) begin
               res_in.blk = tb32[3:0];
               res_in.chk = tc_ff[11:0];
               res_in.cnt = need_ff;
               tc_in = tc_ff + need_ff;
               state_in = S_FIN;
            end else if (biu32 >= 32'(MAX_BLOCKS)) begin
               st_in = ST_NO_BLOCKS;
               state_in = S_FIN;
            end else if (tail && (32'(fc_ff) >= 32'(FREE_ENTRIES))) begin
               st_in = ST_TABLE_FULL;
               state_in = S_FIN;
            end else if (tail) begin
               ins_in.blk = tb32[3:0];
               ins_in.chk = tc_ff[11:0];
               ins_in.cnt = bc - tc_ff;
               open_in = 1'b1;
               i_in = IW'(fc_ff - CW'(1));
               state_in = S_IRD;
            end else begin
               state_in = S_OPEN;
            end
         end
         S_OPEN: begin
            tb_in  = BUW'(biu_ff);
            biu_in = biu_ff + BUW'(1);
            res_in.blk = biu32[3:0];
            res_in.chk = '0;
            res_in.cnt = need_ff;
            tc_in = need_ff;
            state_in = S_FIN;
         end
         S_FREE: begin
            if ((fcnt_ff == '0) || (fcnt_ff >= bc) || (32'(fblk_ff) >= biu32)
                || (13'(fchk_ff) >= bc)) begin
               st_in = ST_BAD_FREE;
               state_in = S_FIN;
            end else if (32'(fc_ff) >= 32'(FREE_ENTRIES)) begin
               st_in = ST_TABLE_FULL;
               state_in = S_FIN;
            end else begin
               ins_in.blk = fblk_ff;
               ins_in.chk = fchk_ff;
               ins_in.cnt = fcnt_ff;
               open_in = 1'b0;
               if (fc_ff == '0) begin
                  i_in = '0;
                  state_in = S_IFIN;
               end else begin
                  i_in = IW'(fc_ff - CW'(1));
                  state_in = S_IRD;
               end
            end
         end
         S_IRD: state_in = S_IEV;
         S_IEV: begin
            // walk down from the top, shifting up every entry not smaller
            if (ram_rdata.cnt >= ins_ff.cnt) begin
               ram_we = 1'b1;
               ram_waddr = IW'(i_ff + 1'b1);
               if (i_ff == '0) begin
                  state_in = S_IFIN;
               end else begin
                  i_in = IW'(i_ff - 1'b1);
                  state_in = S_IRD;
               end
            end else begin
               i_in = IW'(i_ff + 1'b1);
               state_in = S_IFIN;
            end
         end
         S_IFIN: begin
            ram_we = 1'b1;
            ram_waddr = i_ff;
            ram_wdata = ins_ff;
            fc_in = fc_ff + CW'(1);
            state_in = open_ff ? S_OPEN : S_FIN;
         end
         S_FIN: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1;
               ost_in = st_ff;
               ores_in = res_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // a tail insert when fc is zero skips the walk and writes entry zero directly
      if ((state_ff == S_BUMP) && tail && fits == 1'b0 && fc_ff == '0
          && !(biu32 >= 32'(MAX_BLOCKS))) begin
         i_in = '0;
         state_in = S_IFIN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pay_ff   <= 16'd64;
         hdr_ff   <= 8'd16;
         bcr_ff   <= 13'd4096;
         fc_ff    <= '0;
         tb_ff    <= '0;
         biu_ff   <= '0;
         tc_ff    <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pay_ff   <= pay_in;
         hdr_ff   <= hdr_in;
         bcr_ff   <= bcr_in;
         fc_ff    <= fc_in;
         tb_ff    <= tb_in;
         biu_ff   <= biu_in;
         tc_ff    <= tc_in;
         rv_ff    <= rv_in;
      end
      fblk_ff <= fblk_in;
      fchk_ff <= fchk_in;
      fcnt_ff <= fcnt_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      cs_ff   <= cs_in;
      dcnt_ff <= dcnt_in;
      need_ff <= need_in;
      i_ff    <= i_in;
      ins_ff  <= ins_in;
      open_ff <= open_in;
      st_ff   <= st_in;
      res_ff  <= res_in;
      ost_ff  <= ost_in;
      ores_ff <= ores_in;
   end
endmodule

>>> bench/tb.sv
// Self-checking bench for the chunk pool allocator unit.
`timescale 1ns / 1ps
module tb
   import cpa_pkg::*;
();

   typedef struct {
      logic [2:0]  status;
      logic [3:0]  blk;
      logic [11:0] chk;
      logic [12:0] cnt;
   } grant_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_type = 1'b0;
   logic [23:0] req_alloc_bytes = '0;
   logic [3:0]  req_free_block = '0;
   logic [11:0] req_free_chunk = '0;
   logic [12:0] req_free_chunks = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_block_index;
   logic [11:0] rsp_chunk_index;
   logic [12:0] rsp_chunks_granted;

   chunk_pool_allocator_unit dut (.*);

   always #5 clock = ~clock;

   // predictor state
   int unsigned payload_reg, header_reg, block_reg;
   int unsigned pool_blk[FreeEntries], pool_chk[FreeEntries], pool_cnt[FreeEntries];
   int unsigned pool_count, top_blk, top_chk, open_blocks;

   grant_type   grants_due[$];
   int          errors = 0;
   int          send_idle = 0, recv_idle = 0;
   int          quiet_cycles = 0;

   function automatic int unsigned chunks_per_block();
      int unsigned bc;
      bc = block_reg;
      if (bc < 2) bc = 2;
      if (bc > MaxBlockChunks) bc = MaxBlockChunks;
      return bc;
   endfunction

   function automatic void pool_insert(int unsigned b, int unsigned c, int unsigned n);
      int unsigned pos;
      pos = 0;
      while (pos < pool_count && pool_cnt[pos] < n) pos++;
      for (int unsigned i = pool_count; i > pos; i--) begin
         pool_blk[i] = pool_blk[i-1];
         pool_chk[i] = pool_chk[i-1];
         pool_cnt[i] = pool_cnt[i-1];
      end
      pool_blk[pos] = b;
      pool_chk[pos] = c;
      pool_cnt[pos] = n;
      pool_count++;
   endfunction

   function automatic grant_type predict_grant(logic kind, logic [23:0] bytes,
         logic [3:0] fb, logic [11:0] fc, logic [12:0] fn);
      grant_type g;
      int unsigned bc, pay, cs, need;
      bit tail;
      g = '{ST_OK, 0, 0, 0};
      bc = chunks_per_block();
      if (kind == REQ_ALLOC) begin
         pay = payload_reg ? payload_reg : 1;
         cs = pay + header_reg;
         need = (32'(bytes) + header_reg + cs - 1) / cs;
         if (need == 0) need = 1;
         if (need >= bc) begin
            g.status = ST_TOO_LARGE;
            return g;
         end
         for (int unsigned i = 0; i < pool_count; i++) begin
            if (pool_cnt[i] >= need) begin
               g.blk = 4'(pool_blk[i]);
               g.chk = 12'(pool_chk[i]);
               g.cnt = 13'(pool_cnt[i]);
               for (int unsigned j = i; j + 1 < pool_count; j++) begin
                  pool_blk[j] = pool_blk[j+1];
                  pool_chk[j] = pool_chk[j+1];
                  pool_cnt[j] = pool_cnt[j+1];
               end
               pool_count--;
               return g;
            end
         end
         if (!(open_blocks > 0 && top_chk + need < bc)) begin
            tail = open_blocks > 0 && top_chk < bc;
            if (open_blocks >= MaxBlocks) begin
               g.status = ST_NO_BLOCKS;
               return g;
            end
            if (tail && pool_count >= FreeEntries) begin
               g.status = ST_TABLE_FULL;
               return g;
            end
            if (tail) pool_insert(top_blk, top_chk, bc - top_chk);
            top_blk = open_blocks;
            open_blocks++;
            top_chk = 0;
         end
         g.blk = 4'(top_blk);
         g.chk = 12'(top_chk);
         g.cnt = 13'(need);
         top_chk += need;
         return g;
      end
      if (fn == 0 || fn >= bc || fb >= open_blocks || fc >= bc) begin
         g.status = ST_BAD_FREE;
         return g;
      end
      if (pool_count >= FreeEntries) begin
         g.status = ST_TABLE_FULL;
         return g;
      end
      pool_insert(32'(fb), 32'(fc), 32'(fn));
      return g;
   endfunction

   // valid stays high after the beat; a random idle before the next send or a drain drops it
   task automatic send_request(logic kind, logic [23:0] bytes, logic [3:0] fb,
         logic [11:0] fc, logic [12:0] fn);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_alloc_bytes <= bytes;
      req_free_block <= fb;
      req_free_chunk <= fc;
      req_free_chunks <= fn;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      grants_due = {grants_due, predict_grant(kind, bytes, fb, fc, fn)};
   endtask

   task automatic send_alloc(logic [23:0] bytes);
      send_request(REQ_ALLOC, bytes, 0, 0, 0);
   endtask

   task automatic send_free(logic [3:0] fb, logic [11:0] fc, logic [12:0] fn);
      send_request(~REQ_ALLOC, 24'($urandom), fb, fc, fn);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (grants_due.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_PAYLOAD: payload_reg = 32'(value);
         REG_HEADER:  header_reg = 32'(value[7:0]);
         REG_BLOCK:   block_reg = 32'(value[12:0]);
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic restart_pool(int unsigned pay, int unsigned hdr, int unsigned bc);
      drain();
      write_reg(REG_PAYLOAD, 16'(pay));
      write_reg(REG_HEADER, 16'(hdr));
      write_reg(REG_BLOCK, 16'(bc));
   endtask

   // check every result beat against the oldest prediction
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (grants_due.size() == 0) begin
               $error("unexpected result beat status %0d", rsp_status);
               errors++;
            end else begin
               grant_type g;
               g = grants_due.pop_front();
               if (rsp_status !== g.status) begin
                  $error("status exp %0d got %0d", g.status, rsp_status);
                  errors++;
               end
               if (rsp_block_index !== g.blk) begin
                  $error("block_index exp %0d got %0d", g.blk, rsp_block_index);
                  errors++;
               end
               if (rsp_chunk_index !== g.chk) begin
                  $error("chunk_index exp %0d got %0d", g.chk, rsp_chunk_index);
                  errors++;
               end
               if (rsp_chunks_granted !== g.cnt) begin
                  $error("chunks_granted exp %0d got %0d", g.cnt, rsp_chunks_granted);
                  errors++;
               end
            end
         end
         rsp_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);
      end
   end

   // watchdog on beats moved
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("tb failed");
         $finish;
      end
   end

   task automatic test_directed();
      send_free(0, 0, 1);              // no block open yet
      send_alloc(0);
      send_alloc(24'hFFFFFF);          // too large
      send_alloc(64);
      send_free(0, 4095, 1);           // last chunk of the block: a valid free
      send_free(0, 0, 0);              // zero count
      send_free(0, 0, 4096);           // count at block size
      send_free(15, 0, 1);
      send_free(0, 10, 3);
      send_free(0, 20, 3);             // tie
      send_alloc(100);
      send_alloc(1);
      send_alloc(4000 * 80);
      send_alloc(4093 * 80);           // opens new block, tail stored
      send_alloc(80 * 4094);           // needs 4095 chunks: opens another block, tail stored
   endtask

   task automatic test_block_exhaust();
      restart_pool(0, 0, 0);           // payload 0 acts as 1, blocks clamp to 2
      send_alloc(0);
      repeat (40) send_alloc(1);       // every other one opens a block, runs out
      send_free(1, 1, 1);
      send_alloc(1);
   endtask

   task automatic test_table_full();
      restart_pool(16'hFFFF, 255, 3000);
      for (int i = 0; i < 70; i++) send_free(4'd0, 12'(i), 13'(1 + i % 5));
      send_alloc(0);
      for (int i = 0; i < 70; i++) send_free(4'd0, 12'(i), 13'(1 + i % 5));
      drain();                         // hold off until all results return
      send_alloc(24'd9000000);
   endtask

   task automatic test_random(int n, int unsigned pay, int unsigned hdr, int unsigned bc);
      int unsigned bcx;
      restart_pool(pay, hdr, bc);
      bcx = chunks_per_block();
      for (int i = 0; i < n; i++) begin
         int unsigned r;
         r = $urandom_range(99);
         if (r < 55)
            send_alloc(24'($urandom_range(1, 8) == 1 ? $urandom
                                                      : $urandom_range(0, 2000)));
         else if (r < 90)
            send_free(4'($urandom_range(0, open_blocks)),
                      12'($urandom_range(0, bcx - 1)),
                      13'($urandom_range(1, bcx - 1)));
         else
            send_free(4'($urandom), 12'($urandom), 13'($urandom));
      end
   endtask

   initial begin
      payload_reg = 64;
      header_reg = 16;
      block_reg = 4096;
      pool_count = 0;
      top_blk = 0;
      top_chk = 0;
      open_blocks = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle = 38;
      recv_idle = 54;
      test_directed();
      test_block_exhaust();
      test_table_full();
      test_random(400, 64, 16, 4096);
      test_random(0, 1, 0, 8);
      send_idle = 54;
      recv_idle = 38;
      test_random(400, 7, 3, 64);
      send_idle = 0;
      recv_idle = 0;
      test_random(150, 65535, 255, 2);
      test_random(100, 32, 8, 300);
      drain();
      if (errors == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end
endmodule
